[rtl/core/iwd_pkg.sv]
// ----------------------------------------------------------------------------
// iwd_pkg
// Shared types, calendar tables and small arithmetic helpers for the ISO
// week date converter.
// ----------------------------------------------------------------------------
package iwd_pkg;

  // Width of the unreduced residue sum and of a residue mod 400.
  localparam int SUM_W = 16;
  localparam int REM_W = 9;

  // Reciprocal of 400 scaled by 2^RECIP_SHIFT, rounded down.
  localparam int          RECIP_SHIFT = 24;
  localparam logic [15:0] RECIP_400   = 16'd41943;
  localparam logic [9:0]  YEARS_CYCLE = 10'd400;
  localparam logic [8:0]  REM_LAST    = 9'd399;

  localparam logic [5:0] WEEKS_LONG  = 6'd53;
  localparam logic [5:0] WEEKS_SHORT = 6'd52;

  localparam logic [2:0] DAY_WED = 3'd3;
  localparam logic [2:0] DAY_THU = 3'd4;
  localparam logic [2:0] DAY_SUN = 3'd7;

  // Stage enables of the mod-400 unit.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } iwd_mod_en_t;

  // Year split into century code (0..3) and year within century.
  typedef struct packed {
    logic [1:0] cen;
    logic [6:0] yc;
    logic       leap;
  } iwd_cent_t;

  // Floor of v / 7 for v below 512.
  function automatic logic [6:0] div7(input logic [8:0] v);
    logic [21:0] p;
    p = 22'(v) * 22'(586);
    return p[18:12];
  endfunction

  function automatic logic [2:0] mod7(input logic [8:0] v);
    logic [8:0] r;
    r = v - 9'(div7(v)) * 9'd7;
    return r[2:0];
  endfunction

  function automatic iwd_cent_t split400(input logic [8:0] r);
    iwd_cent_t  c;
    logic [8:0] rest;
    priority if (r >= 9'd300) begin
      c.cen = 2'd3;
      rest  = r - 9'd300;
    end else if (r >= 9'd200) begin
      c.cen = 2'd2;
      rest  = r - 9'd200;
    end else if (r >= 9'd100) begin
      c.cen = 2'd1;
      rest  = r - 9'd100;
    end else begin
      c.cen = 2'd0;
      rest  = r;
    end
    c.yc   = rest[6:0];
    c.leap = (rest[1:0] == 2'd0) && ((rest != 9'd0) || (c.cen == 2'd0));
    return c;
  endfunction

  function automatic logic [2:0] mon_off(input logic [3:0] m, input logic leap);
    logic [2:0] o;
    unique case (m)
      4'd1:    o = leap ? 3'd6 : 3'd0;
      4'd2:    o = leap ? 3'd2 : 3'd3;
      4'd3:    o = 3'd3;
      4'd4:    o = 3'd6;
      4'd5:    o = 3'd1;
      4'd6:    o = 3'd4;
      4'd7:    o = 3'd6;
      4'd8:    o = 3'd2;
      4'd9:    o = 3'd5;
      4'd10:   o = 3'd0;
      4'd11:   o = 3'd3;
      4'd12:   o = 3'd5;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

  // Days before the first of month m.
  function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
    logic [8:0] c;
    unique case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

[rtl/core/iwd_mod400.sv]
// ----------------------------------------------------------------------------
// iwd_mod400
// Three-stage unit that gives the non-negative remainder of a signed year
// modulo 400: weighted nibble sum, reciprocal multiply, subtract and correct.
// ----------------------------------------------------------------------------
module iwd_mod400
  import iwd_pkg::*;
#(
  parameter int YEAR_BITS = 16
) (
  input  logic                 clk,
  input  iwd_mod_en_t          en,
  input  logic [YEAR_BITS-1:0] year,
  output logic [REM_W-1:0]     rem
);

  localparam int NCH   = (YEAR_BITS - 1 + 3) / 4;
  localparam int LOW_W = NCH * 4;
  // Sign bit weighs -2^(YEAR_BITS-1), taken here as its positive residue.
  localparam logic [8:0] SIGN_WGT =
    9'((400 - ((64'd1 << (YEAR_BITS - 1)) % 400)) % 400);

  logic [LOW_W-1:0] ylo;
  logic [SUM_W-1:0] part [NCH];
  logic [SUM_W-1:0] sum_nxt;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum2_r;
  logic [7:0]       quo_r;
  logic [31:0]      prod;
  logic [SUM_W-1:0] diff;
  logic [REM_W-1:0] rem_nxt;
  logic [REM_W-1:0] rem_r;

  assign ylo = LOW_W'(year[YEAR_BITS-2:0]);

  for (genvar j = 0; j < NCH; j++) begin : g_chunk
    localparam logic [8:0] WGT = 9'((64'd1 << (4 * j)) % 400);
    assign part[j] = SUM_W'(ylo[4*j +: 4]) * SUM_W'(WGT);
  end

  always_comb begin
    sum_nxt = year[YEAR_BITS-1] ? SUM_W'(SIGN_WGT) : '0;
    for (int j = 0; j < NCH; j++) begin
      sum_nxt = sum_nxt + part[j];
    end
  end

  assign prod = 32'(sum_r) * 32'(RECIP_400);

  // Quotient is exact or one short; fix with one subtract.
  always_comb begin
    diff = sum2_r - SUM_W'(quo_r) * SUM_W'(YEARS_CYCLE);
    if (diff >= SUM_W'(YEARS_CYCLE)) begin
      diff = diff - SUM_W'(YEARS_CYCLE);
    end
    rem_nxt = diff[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      sum_r <= sum_nxt;
    end
    if (en.s2) begin
      quo_r  <= prod[RECIP_SHIFT +: 8];
      sum2_r <= sum_r;
    end
    if (en.s3) begin
      rem_r <= rem_nxt;
    end
  end

  assign rem = rem_r;

endmodule

[rtl/core/iso_week_date_from_date_unit.sv]
// ----------------------------------------------------------------------------
// iso_week_date_from_date_unit
// Converts a proleptic Gregorian date into an ISO 8601 week date.
// ----------------------------------------------------------------------------
// One date enters per clock cycle while in_ready is high; each passes through
// the seven-stage pipeline (year mod 400, century split, weekday sums, mod 7,
// week decision). When the output is held, stages with a
// bubble still fill, so input stops only once every stage is occupied. A bad
// month or day gives input_ok low and all other result fields zero.
module iso_week_date_from_date_unit
  import iwd_pkg::*;
#(
  parameter int YEAR_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [YEAR_BITS-1:0] in_year,
  input  logic        [3:0]           in_month,
  input  logic        [4:0]           in_day,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [YEAR_BITS-1:0] out_iso_year,
  output logic        [5:0]           out_iso_week,
  output logic        [2:0]           out_iso_weekday,
  output logic                        out_input_ok
);

  localparam int STAGES = 7;

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] en;
  iwd_mod_en_t       mod_en;
  logic [REM_W-1:0]  rem;

  logic [YEAR_BITS-1:0] y_r [6];
  logic [3:0]           m_r [4];
  logic [4:0]           d_r [4];

  // stage 4
  logic [REM_W-1:0] rem_m1;
  iwd_cent_t        cy_nxt, cm_nxt, cy_r, cm_r;
  // stage 5
  logic [7:0] base_y, base_m;
  logic [7:0] x_nxt, x1_nxt, xm1_nxt, x_r, x1_r, xm1_r;
  logic [8:0] doy_nxt, doy5_r, doy6_r;
  logic       ok_nxt, ok5_r, ok6_r;
  logic       lp5_r, lpm5_r, lp6_r, lpm6_r;
  // stage 6
  logic [2:0] wd_nxt, j1_nxt, j1m_nxt, wd_r, j1_r, j1m_r;
  // stage 7
  logic [8:0]           wk_arg;
  logic [5:0]           wk;
  logic [5:0]           weeks_y, weeks_m;
  logic [YEAR_BITS-1:0] iso_year_nxt;
  logic [5:0]           iso_week_nxt;
  logic [YEAR_BITS-1:0] iso_year_r;
  logic [5:0]           iso_week_r;
  logic [2:0]           iso_wd_r;
  logic                 ok_r;

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    en[STAGES-1] = !v_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign mod_en = '{s1: en[0], s2: en[1], s3: en[2]};

  iwd_mod400 #(
    .YEAR_BITS(YEAR_BITS)
  ) u_mod400 (
    .clk (clk),
    .en  (mod_en),
    .year(in_year),
    .rem (rem)
  );

  // Stage 4: century code, year in century and leap flag for y and y-1.
  always_comb begin
    rem_m1 = (rem == '0) ? REM_LAST : rem - 9'd1;
    cy_nxt = split400(rem);
    cm_nxt = split400(rem_m1);
  end

  // Stage 5: date check, day of year and the three weekday sums.
  always_comb begin
    base_y  = 8'(3'd6 - {cy_r.cen, 1'b0}) + 8'(cy_r.yc) + 8'(cy_r.yc >> 2);
    base_m  = 8'(3'd6 - {cm_r.cen, 1'b0}) + 8'(cm_r.yc) + 8'(cm_r.yc >> 2);
    x_nxt   = base_y + 8'(mon_off(m_r[3], cy_r.leap)) + 8'(d_r[3]);
    x1_nxt  = base_y + 8'(mon_off(4'd1, cy_r.leap)) + 8'd1;
    xm1_nxt = base_m + 8'(mon_off(4'd1, cm_r.leap)) + 8'd1;
    doy_nxt = cum_days(m_r[3], cy_r.leap) + 9'(d_r[3]);
    ok_nxt  = (m_r[3] >= 4'd1) && (m_r[3] <= 4'd12) && (d_r[3] != 5'd0)
              && (d_r[3] <= month_len(m_r[3], cy_r.leap));
  end

  // Stage 6: reduce mod 7, Sunday as 7.
  always_comb begin
    wd_nxt  = mod7(9'(x_r));
    j1_nxt  = mod7(9'(x1_r));
    j1m_nxt = mod7(9'(xm1_r));
    if (wd_nxt == 3'd0) begin
      wd_nxt = DAY_SUN;
    end
    if (j1_nxt == 3'd0) begin
      j1_nxt = DAY_SUN;
    end
    if (j1m_nxt == 3'd0) begin
      j1m_nxt = DAY_SUN;
    end
  end

  // Stage 7: week number and the move into the neighboring ISO year.
  always_comb begin
    wk_arg  = doy6_r - 9'(wd_r) + 9'd10;
    wk      = 6'(div7(wk_arg));
    weeks_y = ((j1_r == DAY_THU) || ((j1_r == DAY_WED) && lp6_r))
              ? WEEKS_LONG : WEEKS_SHORT;
    weeks_m = ((j1m_r == DAY_THU) || ((j1m_r == DAY_WED) && lpm6_r))
              ? WEEKS_LONG : WEEKS_SHORT;
    iso_year_nxt = y_r[5];
    iso_week_nxt = wk;
    priority if (wk == 6'd0) begin
      iso_year_nxt = y_r[5] - YEAR_BITS'(1);
      iso_week_nxt = weeks_m;
    end else if (wk > weeks_y) begin
      iso_year_nxt = y_r[5] + YEAR_BITS'(1);
      iso_week_nxt = 6'd1;
    end else begin
      iso_year_nxt = y_r[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y_r[0] <= in_year;
      m_r[0] <= in_month;
      d_r[0] <= in_day;
    end
    for (int k = 1; k < 6; k++) begin
      if (en[k]) begin
        y_r[k] <= y_r[k-1];
      end
    end
    for (int k = 1; k < 4; k++) begin
      if (en[k]) begin
        m_r[k] <= m_r[k-1];
        d_r[k] <= d_r[k-1];
      end
    end
    if (en[3]) begin
      cy_r <= cy_nxt;
      cm_r <= cm_nxt;
    end
    if (en[4]) begin
      x_r    <= x_nxt;
      x1_r   <= x1_nxt;
      xm1_r  <= xm1_nxt;
      doy5_r <= doy_nxt;
      ok5_r  <= ok_nxt;
      lp5_r  <= cy_r.leap;
      lpm5_r <= cm_r.leap;
    end
    if (en[5]) begin
      wd_r   <= wd_nxt;
      j1_r   <= j1_nxt;
      j1m_r  <= j1m_nxt;
      doy6_r <= doy5_r;
      ok6_r  <= ok5_r;
      lp6_r  <= lp5_r;
      lpm6_r <= lpm5_r;
    end
    if (en[6]) begin
      // Drop every field to zero for an invalid date.
      iso_year_r <= ok6_r ? iso_year_nxt : '0;
      iso_week_r <= ok6_r ? iso_week_nxt : '0;
      iso_wd_r   <= ok6_r ? wd_r : '0;
      ok_r       <= ok6_r;
    end
  end

  assign out_iso_year    = iso_year_r;
  assign out_iso_week    = iso_week_r;
  assign out_iso_weekday = iso_wd_r;
  assign out_input_ok    = ok_r;

endmodule
